// ===== src/bdpc_pkg.sv =====
// shared types and constants of the button debounce and press classifier
`timescale 1ns / 1ps
`default_nettype none
package bdpc_pkg;

	localparam int unsigned TimeW  = 32;
	localparam int unsigned MsW    = 16;
	localparam int unsigned CfgIdxW = 3;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_ACTIVE_LOW   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_SHORT_MIN_MS = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SHORT_MAX_MS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_LONG_MIN_MS  = 3'd4;

	// reset values
	localparam logic           RST_ACTIVE_LOW   = 1'b1;
	localparam logic [MsW-1:0] RST_DEBOUNCE_MS  = 16'd30;
	localparam logic [MsW-1:0] RST_SHORT_MIN_MS = 16'd50;
	localparam logic [MsW-1:0] RST_SHORT_MAX_MS = 16'd700;
	localparam logic [MsW-1:0] RST_LONG_MIN_MS  = 16'd2000;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2
	} press_ev_t;

	typedef struct packed {
		logic           active_low;
		logic [MsW-1:0] debounce_ms;
		logic [MsW-1:0] short_min_ms;
		logic [MsW-1:0] short_max_ms;
		logic [MsW-1:0] long_min_ms;
	} bdpc_cfg_t;

endpackage
`default_nettype wire

// ===== src/bdpc_cfg_regs.sv =====
// configuration register file of the press classifier
`timescale 1ns / 1ps
`default_nettype none
module bdpc_cfg_regs
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [CfgIdxW-1:0] wr_index,
	input  wire logic [MsW-1:0]     wr_data,
	output bdpc_cfg_t               cfg
);

	bdpc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low   <= RST_ACTIVE_LOW;
			cfg_q.debounce_ms  <= RST_DEBOUNCE_MS;
			cfg_q.short_min_ms <= RST_SHORT_MIN_MS;
			cfg_q.short_max_ms <= RST_SHORT_MAX_MS;
			cfg_q.long_min_ms  <= RST_LONG_MIN_MS;
		end else if (wr_en) begin
			// unknown indexes are dropped
			unique case (wr_index)
				REG_ACTIVE_LOW:   cfg_q.active_low   <= wr_data[0];
				REG_DEBOUNCE_MS:  cfg_q.debounce_ms  <= wr_data;
				REG_SHORT_MIN_MS: cfg_q.short_min_ms <= wr_data;
				REG_SHORT_MAX_MS: cfg_q.short_max_ms <= wr_data;
				REG_LONG_MIN_MS:  cfg_q.long_min_ms  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/bdpc_core.sv =====
// debounce state and press classification for one poll per enabled cycle
`timescale 1ns / 1ps
`default_nettype none
module bdpc_core
	import bdpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             pin,
	input  wire logic [TimeW-1:0] now,
	input  wire bdpc_cfg_t        cfg,
	output press_ev_t             ev
);

	logic             last_raw_q;
	logic             stable_q;
	logic             long_done_q;
	logic [TimeW-1:0] raw_change_q;
	logic [TimeW-1:0] press_start_q;

	logic             pressed;
	logic             raw_chg;
	logic [TimeW-1:0] deb_diff;
	logic [TimeW-1:0] dur;
	logic             settling;
	logic             long_hit;
	logic             short_hit;

	logic             stable_d;
	logic             long_done_d;
	logic [TimeW-1:0] press_start_d;

	assign pressed   = cfg.active_low ? ~pin : pin;
	assign raw_chg   = pressed != last_raw_q;
	// a fresh change restarts the timer at now, so the difference is zero
	assign deb_diff  = raw_chg ? '0 : now - raw_change_q;
	assign dur       = now - press_start_q;
	assign settling  = deb_diff < {{(TimeW-MsW){1'b0}}, cfg.debounce_ms};
	assign long_hit  = stable_q && !long_done_q
		&& dur >= {{(TimeW-MsW){1'b0}}, cfg.long_min_ms};
	assign short_hit = dur >= {{(TimeW-MsW){1'b0}}, cfg.short_min_ms}
		&& dur < {{(TimeW-MsW){1'b0}}, cfg.short_max_ms};

	always_comb begin
		stable_d      = stable_q;
		long_done_d   = long_done_q;
		press_start_d = press_start_q;
		ev            = EV_NONE;
		if (!settling && stable_q != pressed) begin
			stable_d = pressed;
			if (pressed) begin
				press_start_d = now;
				long_done_d   = 1'b0;
			end else if (short_hit) begin
				ev = EV_SHORT;
			end
		end else if (long_hit) begin
			long_done_d = 1'b1;
			ev          = EV_LONG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			long_done_q   <= 1'b0;
			raw_change_q  <= '0;
			press_start_q <= '0;
		end else if (en) begin
			last_raw_q    <= pressed;
			stable_q      <= stable_d;
			long_done_q   <= long_done_d;
			press_start_q <= press_start_d;
			if (raw_chg) begin
				raw_change_q <= now;
			end
		end
	end

	a_long_sets_done: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev == EV_LONG |=> long_done_q)
		else $error("long press did not mark the press as reported");

	a_short_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev == EV_SHORT |=> !stable_q)
		else $error("short press reported without a release");

	a_no_double_long: assert property (@(posedge clk) disable iff (!arst_n)
		en && ev == EV_LONG |=> !(en && ev == EV_LONG))
		else $error("two long presses in consecutive polls");

endmodule
`default_nettype wire

// ===== src/button_debounce_press_classifier.sv =====
// top level of the button debounce and press classifier
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  in      | input     | in_valid/in_stall  | pin_level, now_ms
//  out     | output    | out_valid/out_stall| press_event
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one poll per cycle sustained while out_stall is low; a poll goes from
// input accept to result through the input and result registers.
// state is updated once per poll when it moves into the result register.
// reset puts the button in the released state with timestamps at zero.
// a stalled result holds the pipe; the input register still takes one poll.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_press_classifier
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               pin_level,
	input  wire logic [TimeW-1:0]   now_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              press_event,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [MsW-1:0]     cfg_data
);

	bdpc_cfg_t        cfg;
	logic             valid_s1;
	logic             pin_s1;
	logic [TimeW-1:0] now_s1;
	logic             valid_s2;
	press_ev_t        ev_s2;
	press_ev_t        ev;
	logic             adv_s2;
	logic             adv_s1;

	assign cfg_ready = 1'b1;

	bdpc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			pin_s1 <= pin_level;
			now_s1 <= now_ms;
		end
	end

	bdpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s2 && valid_s1),
		.pin    (pin_s1),
		.now    (now_s1),
		.cfg    (cfg),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			ev_s2 <= ev;
		end
	end

	assign out_valid   = valid_s2;
	assign press_event = ev_s2;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// self-checking testbench for the button debounce and press classifier
`timescale 1ns / 1ps
module testbench;
	import bdpc_pkg::*;

	localparam int unsigned STALL_PCT         = 14;
	localparam int unsigned POLLS_PER_SETTING = 170;
	localparam int unsigned HOLD_AT_POLL      = 600;
	localparam int unsigned HOLD_CYCLES       = 80;
	localparam int unsigned STUCK_LIMIT       = 1000;

	typedef struct packed {
		logic             pin;
		logic [TimeW-1:0] now;
	} poll_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               pin_level = 1'b1;
	logic [TimeW-1:0]   now_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         press_event;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [MsW-1:0]     cfg_data = '0;

	button_debounce_press_classifier u_top (.*);

	initial forever #5 clk = ~clk;

	// press tracking state mirrored from the block
	bdpc_cfg_t        cfg_model;
	logic             level_down = 1'b0;
	logic             held = 1'b0;
	logic             long_flagged = 1'b0;
	logic [TimeW-1:0] raw_change_at = '0;
	logic [TimeW-1:0] press_began_at = '0;

	poll_t       pending_polls[$];
	press_ev_t   expected_events[$];
	poll_t       next_poll;
	press_ev_t   want;
	int unsigned polls_queued = 0;
	int unsigned polls_accepted = 0;
	int unsigned events_checked = 0;
	int unsigned shorts_seen = 0;
	int unsigned longs_seen = 0;
	int unsigned settings_applied = 0;
	int unsigned fail_count = 0;
	int unsigned stuck_cycles = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	logic        calm = 1'b0;
	logic [TimeW-1:0] t_cursor = '0;
	int unsigned step_max = 1;

	function automatic press_ev_t long_hold_check(input logic [TimeW-1:0] now);
		logic [TimeW-1:0] held_for;
		held_for = now - press_began_at;
		if (held && !long_flagged && held_for >= TimeW'(cfg_model.long_min_ms)) begin
			long_flagged = 1'b1;
			return EV_LONG;
		end
		return EV_NONE;
	endfunction

	function automatic press_ev_t predict_press(input logic pin, input logic [TimeW-1:0] now);
		logic             pressed;
		logic [TimeW-1:0] span;
		pressed = cfg_model.active_low ? ~pin : pin;
		if (pressed != level_down) begin
			level_down = pressed;
			raw_change_at = now;
		end
		span = now - raw_change_at;
		if (span < TimeW'(cfg_model.debounce_ms))
			return long_hold_check(now);
		if (held == level_down)
			return long_hold_check(now);
		held = level_down;
		if (held) begin
			press_began_at = now;
			long_flagged = 1'b0;
			return EV_NONE;
		end
		span = now - press_began_at;
		if (span >= TimeW'(cfg_model.short_min_ms) && span < TimeW'(cfg_model.short_max_ms))
			return EV_SHORT;
		return EV_NONE;
	endfunction

	task automatic queue_poll(input logic pin, input logic [TimeW-1:0] now);
		pending_polls.push_back(poll_t'{pin, now});
		polls_queued++;
	endtask

	// polls at random steps that land exactly span ms ahead
	task automatic walk_for(input logic pin, input int unsigned span);
		int unsigned step;
		do begin
			step = $urandom_range(step_max, 1);
			if (step > span)
				step = span;
			span -= step;
			t_cursor += step;
			queue_poll(pin, t_cursor);
		end while (span > 0);
	endtask

	// press length measured from the raw press edge to the raw release edge
	function automatic int unsigned pick_hold();
		int unsigned deb, smin, smax, lmin;
		deb = 32'(cfg_model.debounce_ms);
		smin = 32'(cfg_model.short_min_ms);
		smax = 32'(cfg_model.short_max_ms);
		lmin = 32'(cfg_model.long_min_ms);
		case ($urandom_range(7))
			0: return smin;
			1: return (smin > 0) ? smin - 1 : 0;
			2: return smax;
			3: return (smax > 0) ? smax - 1 : 0;
			4: return deb + lmin;
			5: return deb + lmin + $urandom_range(step_max);
			default: return $urandom_range(deb + lmin + smax + 1);
		endcase
	endfunction

	task automatic queue_press_episode();
		logic        down;
		int unsigned deb, lmin, press_span, first, rest;
		down = ~cfg_model.active_low;
		deb = 32'(cfg_model.debounce_ms);
		lmin = 32'(cfg_model.long_min_ms);
		press_span = pick_hold();
		press_span = (press_span > 0) ? press_span - 1 : 0;
		repeat ($urandom_range(2))
			walk_for(1'($urandom_range(1)), $urandom_range(deb));
		walk_for(down, $urandom_range(step_max, 1));
		first = (press_span < deb) ? press_span : deb;
		walk_for(down, first);
		rest = press_span - first;
		if (rest > lmin && $urandom_range(1)) begin
			// land right on the long press threshold
			walk_for(down, lmin);
			rest -= lmin;
		end
		walk_for(down, rest);
		walk_for(~down, 1);
		if ($urandom_range(3) == 0) begin
			walk_for(down, $urandom_range(deb));
			walk_for(~down, 1);
		end
		walk_for(~down, deb);
		walk_for(~down, $urandom_range(deb + step_max));
	endtask

	// arbitrary levels at arbitrary times, time may jump back
	task automatic queue_noise();
		repeat ($urandom_range(6, 1)) begin
			t_cursor = $urandom;
			queue_poll(1'($urandom_range(1)), t_cursor);
		end
	endtask

	task automatic wait_drained();
		while (pending_polls.size() != 0 || in_valid || expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_setting(input bdpc_cfg_t s);
		logic [CfgIdxW-1:0] idx [6];
		logic [MsW-1:0]     val [6];
		logic [MsW-1:0]     junk;
		junk = MsW'($urandom);
		// upper bits of the active_low write and the unmapped index are ignored
		idx = '{REG_ACTIVE_LOW, REG_DEBOUNCE_MS, REG_SHORT_MIN_MS,
			CfgIdxW'(REG_LONG_MIN_MS + $urandom_range(3, 1)), REG_SHORT_MAX_MS,
			REG_LONG_MIN_MS};
		val = '{{junk[MsW-1:1], s.active_low}, s.debounce_ms, s.short_min_ms,
			MsW'($urandom), s.short_max_ms, s.long_min_ms};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				REG_ACTIVE_LOW:   cfg_model.active_low = val[i][0];
				REG_DEBOUNCE_MS:  cfg_model.debounce_ms = val[i];
				REG_SHORT_MIN_MS: cfg_model.short_min_ms = val[i];
				REG_SHORT_MAX_MS: cfg_model.short_max_ms = val[i];
				REG_LONG_MIN_MS:  cfg_model.long_min_ms = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	task automatic run_setting(input bdpc_cfg_t s, input logic [TimeW-1:0] start);
		int unsigned target;
		apply_setting(s);
		step_max = (s.long_min_ms + s.short_max_ms) / 16 + 1;
		t_cursor = start;
		target = polls_queued + POLLS_PER_SETTING;
		while (polls_queued < target) begin
			if ($urandom_range(99) < 15)
				queue_noise();
			else
				queue_press_episode();
		end
		wait_drained();
	endtask

	function automatic bdpc_cfg_t random_setting();
		bdpc_cfg_t s;
		s.active_low = 1'($urandom_range(1));
		s.debounce_ms = MsW'($urandom_range(12));
		s.short_min_ms = MsW'($urandom_range(30));
		s.short_max_ms = s.short_min_ms + MsW'($urandom_range(60));
		s.long_min_ms = MsW'($urandom_range(150, 20));
		return s;
	endfunction

	// poll driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_events.push_back(predict_press(pin_level, now_ms));
				polls_accepted <= polls_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_polls.size() != 0 && (calm || $urandom_range(99) >= STALL_PCT)) begin
					next_poll = pending_polls.pop_front();
					in_valid <= 1'b1;
					pin_level <= next_poll.pin;
					now_ms <= next_poll.now;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && polls_accepted >= HOLD_AT_POLL) begin
			// long hold-off so the pipe fills and backs up the input
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < STALL_PCT;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_events.size() == 0) begin
				$error("press_event: unexpected transaction, actual %0d", press_event);
				fail_count++;
			end else begin
				want = expected_events.pop_front();
				if (press_event !== want) begin
					$error("press_event mismatch: expected %0d, actual %0d", want, press_event);
					fail_count++;
				end
				case (want)
					EV_SHORT: shorts_seen++;
					EV_LONG:  longs_seen++;
					default: ;
				endcase
				events_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		cfg_model = '{RST_ACTIVE_LOW, RST_DEBOUNCE_MS, RST_SHORT_MIN_MS, RST_SHORT_MAX_MS,
			RST_LONG_MIN_MS};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: low pin level is pressed, 30 ms debounce
		queue_poll(1'b1, 32'd0);
		queue_poll(1'b0, 32'd100);
		queue_poll(1'b0, 32'd129);
		queue_poll(1'b0, 32'd130);
		queue_poll(1'b1, 32'd179);
		queue_poll(1'b1, 32'd209);          // short press
		queue_poll(1'b0, 32'd1000);
		queue_poll(1'b1, 32'd1010);         // bounce restarts debounce
		queue_poll(1'b0, 32'd1015);
		queue_poll(1'b0, 32'd1045);
		queue_poll(1'b0, 32'd3044);
		queue_poll(1'b0, 32'd3045);         // long press
		queue_poll(1'b0, 32'd5000);         // only one long per press
		queue_poll(1'b1, 32'd5001);
		queue_poll(1'b1, 32'd5031);         // too long to be short
		queue_poll(1'b0, 32'hFFFF_FFF0);
		queue_poll(1'b0, 32'h0000_000E);    // debounce across the wrap
		queue_poll(1'b1, 32'h0000_0010);
		queue_poll(1'b1, 32'h0000_0001);    // time going backwards
		queue_poll(1'b0, 32'hFFFF_FFFF);
		queue_poll(1'b0, 32'h0000_0000);
		queue_poll(1'b1, 32'h8000_0000);
		wait_drained();

		run_setting('{RST_ACTIVE_LOW, RST_DEBOUNCE_MS, RST_SHORT_MIN_MS, RST_SHORT_MAX_MS,
			RST_LONG_MIN_MS}, 32'hFFFF_F000);
		run_setting('{1'b0, 16'd0, 16'd0, 16'd0, 16'd0}, $urandom);
		calm <= 1'b1;
		run_setting('{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, $urandom);
		calm <= 1'b0;
		// empty short window
		run_setting('{1'b0, 16'd5, 16'd20, 16'd10, 16'd60}, $urandom);
		// short window reaching past the long threshold
		run_setting('{1'b1, 16'd3, 16'd10, 16'd80, 16'd40}, $urandom);
		run_setting('{1'b0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0}, $urandom);
		repeat (3) run_setting(random_setting(), $urandom);

		wait_drained();
		repeat (10) @(posedge clk);
		if (expected_events.size() != 0) begin
			$error("press_event: %0d transactions never arrived", expected_events.size());
			fail_count++;
		end
		$display("summary: %0d polls checked across %0d register settings",
			events_checked, settings_applied);
		$display("summary: %0d short and %0d long presses reported", shorts_seen, longs_seen);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bdpc_pkg.sv
src/bdpc_cfg_regs.sv
src/bdpc_core.sv
src/button_debounce_press_classifier.sv
verif/testbench.sv
